[sv/tsn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_pkg
// Shared types and codes for the tetrahedron strain norm accumulator.
// ----------------------------------------------------------------------------
package tsn_pkg;

  localparam int NORM_W  = 20;
  localparam int TOTAL_W = 28;
  localparam int THR_W   = 20;
  localparam int F_W     = 16;
  localparam int BODY_W  = 4;
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_THR_VERY_LOW  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_THR_LOW       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_THR_MEDIUM    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_THR_HIGH      = 3'd3;
  localparam logic [CIDX_W-1:0] REG_THR_VERY_HIGH = 3'd4;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_ADD   = 1'b1;

  typedef enum logic [2:0] {
    LVL_NONE      = 3'd0,
    LVL_VERY_LOW  = 3'd1,
    LVL_LOW       = 3'd2,
    LVL_MEDIUM    = 3'd3,
    LVL_HIGH      = 3'd4,
    LVL_VERY_HIGH = 3'd5
  } level_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_MAG,
    ST_SQ,
    ST_SUM0,
    ST_SUM1,
    ST_ROOT,
    ST_DONE
  } state_t;

  // Control shared by all lanes.
  typedef struct packed {
    logic       acc_clr;
    logic       mul_en;
    logic [1:0] k;
    logic       acc_en;
    logic       mag_en;
    logic       sq_en;
  } lane_ctl_t;

endpackage : tsn_pkg
`default_nettype wire

[sv/tsn_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_lane
// One entry of E: dot product of two columns of F, accumulated term by term, minus
// the identity on the diagonal, scaled magnitude, then squared.
// ----------------------------------------------------------------------------
module tsn_lane #(
  parameter int FRAC_BITS = 12,
  parameter int DW        = 35,
  parameter int MW        = 26,
  parameter bit DIAG      = 1'b0
) (
  input  wire                           clk,
  input  wire tsn_pkg::lane_ctl_t       ctl,
  input  wire logic signed [15:0]       col_a [3],
  input  wire logic signed [15:0]       col_b [3],
  output logic [2*MW-1:0]               sq
);
  import tsn_pkg::*;

  localparam logic signed [DW-1:0] ONE = DIAG ? (DW'(1) << (2*FRAC_BITS)) : '0;

  logic signed [31:0]   prod;
  logic signed [DW-1:0] acc;
  logic signed [DW-1:0] d;
  logic        [DW-1:0] dabs;
  logic        [MW-1:0] m;

  always_comb begin
    d    = acc - ONE;
    dabs = d[DW-1] ? DW'(-d) : DW'(d);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= col_a[ctl.k] * col_b[ctl.k];
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(DW-32){prod[31]}}, prod};
    end
    if (ctl.mag_en) begin
      m <= MW'(dabs >> (FRAC_BITS - 3));
    end
    if (ctl.sq_en) begin
      sq <= {{MW{1'b0}}, m} * {{MW{1'b0}}, m};
    end
  end

endmodule : tsn_lane
`default_nettype wire

[sv/tsn_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_merge
// Two-level registered adder tree over the nine lane squares.
// ----------------------------------------------------------------------------
module tsn_merge #(
  parameter int QW = 52,
  parameter int SW = 56
) (
  input  wire              clk,
  input  wire              en0,
  input  wire              en1,
  input  wire [QW-1:0]     sq [9],
  output logic [SW-1:0]    sum
);
  import tsn_pkg::*;

  logic [SW-1:0] part [3];

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      if (en0) begin
        part[g] <= SW'(sq[3*g]) + SW'(sq[3*g+1]) + SW'(sq[3*g+2]);
      end
    end
    if (en1) begin
      sum <= part[0] + part[1] + part[2];
    end
  end

endmodule : tsn_merge
`default_nettype wire

[sv/tsn_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_isqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tsn_isqrt #(
  parameter int SW = 56
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [SW-1:0]     s_in,
  output logic              done,
  output logic [SW/2-1:0]   root
);
  import tsn_pkg::*;

  localparam int RW = SW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [SW-1:0]  sreg;
  logic [RW:0]    rem;
  logic [CW-1:0]  cnt;
  logic           run;
  logic [RW+2:0]  rem_sh;
  logic [RW+2:0]  trial;
  logic           take;

  always_comb begin
    rem_sh = {rem, sreg[SW-1:SW-2]};
    trial  = {1'b0, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      sreg <= s_in;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      sreg <= sreg << 2;
      if (take) begin
        rem  <= (RW+1)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= (RW+1)'(rem_sh);
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule : tsn_isqrt
`default_nettype wire

[sv/tet_strain_norm_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tet_strain_norm_accumulator
// Green-Lagrange strain Frobenius norm of a tetrahedron, level classification
// and saturating per-body totals.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------
//   request  | req_type, body, f00..f22                | start && !busy
//   result   | tet_norm, level, body_total             | done, one cycle
//   config   | cfg_index, cfg_data                     | cfg_we
//
// An add transaction steps through the MAC, magnitude, square, sum and
// bit-serial square root states before its result, the root being RW bits
// wide (28 at FRAC_BITS 12). A clear transaction goes straight to the finishing
// state. One transaction is in flight at a time; the next one can be
// accepted at the edge that takes the result. After reset the totals memory
// is swept to zero entry by entry, busy high. The receiver cannot stall;
// done lasts one cycle.
// ----------------------------------------------------------------------------
module tet_strain_norm_accumulator #(
  parameter int BODIES    = 16,
  parameter int FRAC_BITS = 12
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire                  req_type,
  input  wire  [3:0]           body,
  input  wire  signed [15:0]   f00,
  input  wire  signed [15:0]   f01,
  input  wire  signed [15:0]   f02,
  input  wire  signed [15:0]   f10,
  input  wire  signed [15:0]   f11,
  input  wire  signed [15:0]   f12,
  input  wire  signed [15:0]   f20,
  input  wire  signed [15:0]   f21,
  input  wire  signed [15:0]   f22,
  output logic                 done,
  output logic [19:0]          tet_norm,
  output logic [2:0]           level,
  output logic [27:0]          body_total,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [19:0]          cfg_data
);
  import tsn_pkg::*;

  localparam int DW = (2*FRAC_BITS + 2 > 35) ? 2*FRAC_BITS + 2 : 35;
  localparam int MW = DW - FRAC_BITS + 3;
  localparam int QW = 2 * MW;
  localparam int SW = QW + 4;
  localparam int RW = SW / 2;
  localparam int AW = (BODIES > 1) ? $clog2(BODIES) : 1;

  localparam logic [THR_W-1:0] THR0 = THR_W'(((64'd2  << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [THR_W-1:0] THR1 = THR_W'(((64'd10 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [THR_W-1:0] THR2 = THR_W'(((64'd20 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [THR_W-1:0] THR3 = THR_W'(((64'd30 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [THR_W-1:0] THR4 = THR_W'(((64'd40 << FRAC_BITS) + 64'd50) / 64'd100);

  state_t state, state_next;
  lane_ctl_t ctl;

  logic [1:0]            cnt;
  logic [AW-1:0]         clr_addr;
  logic [THR_W-1:0]      thr [5];
  logic signed [15:0]    fq [3][3];
  logic                  req_q;
  logic                  ok_q;
  logic [AW-1:0]         addr_q;
  logic [TOTAL_W-1:0]    mem [BODIES];
  logic [TOTAL_W-1:0]    rd_data;
  logic [QW-1:0]         sq [9];
  logic [SW-1:0]         sum;
  logic                  root_done;
  logic [RW-1:0]         root;
  logic                  accept;
  logic                  body_ok;
  logic [NORM_W-1:0]     norm;
  level_t                lvl;
  logic [TOTAL_W:0]      tot_sum;
  logic [TOTAL_W-1:0]    tot_sat;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign body_ok = 32'(body) < BODIES;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr[0] <= THR0;
      thr[1] <= THR1;
      thr[2] <= THR2;
      thr[3] <= THR3;
      thr[4] <= THR4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THR_VERY_LOW:  thr[0] <= cfg_data;
        REG_THR_LOW:       thr[1] <= cfg_data;
        REG_THR_MEDIUM:    thr[2] <= cfg_data;
        REG_THR_HIGH:      thr[3] <= cfg_data;
        REG_THR_VERY_HIGH: thr[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (accept) begin
      fq[0][0] <= f00; fq[0][1] <= f01; fq[0][2] <= f02;
      fq[1][0] <= f10; fq[1][1] <= f11; fq[1][2] <= f12;
      fq[2][0] <= f20; fq[2][1] <= f21; fq[2][2] <= f22;
      req_q    <= req_type;
      ok_q     <= body_ok;
      addr_q   <= AW'(32'(body));
    end
  end

  // Lanes: entry (i, j) is the dot product of columns i and j.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [15:0] col_a [3];
      logic signed [15:0] col_b [3];
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign col_a[k] = fq[k][i];
        assign col_b[k] = fq[k][j];
      end
      tsn_lane #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW),
        .MW        (MW),
        .DIAG      (i == j)
      ) u_lane (
        .clk   (clk),
        .ctl   (ctl),
        .col_a (col_a),
        .col_b (col_b),
        .sq    (sq[3*i+j])
      );
    end
  end

  tsn_merge #(.QW(QW), .SW(SW)) u_merge (
    .clk (clk),
    .en0 (state == ST_SUM0),
    .en1 (state == ST_SUM1),
    .sq  (sq),
    .sum (sum)
  );

  tsn_isqrt #(.SW(SW)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_ROOT && state_next == ST_ROOT && cnt == 2'd0),
    .s_in  (sum),
    .done  (root_done),
    .root  (root)
  );

  // Controller.
  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.k       = cnt;
    ctl.acc_clr = accept;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(BODIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (req_type == REQ_ADD) ? ST_MAC : ST_DONE;
      end
      ST_MAC: begin
        ctl.mul_en = (cnt != 2'd3);
        ctl.acc_en = (cnt != 2'd0);
        if (cnt == 2'd3) state_next = ST_MAG;
      end
      ST_MAG:  begin ctl.mag_en = 1'b1; state_next = ST_SQ; end
      ST_SQ:   begin ctl.sq_en = 1'b1; state_next = ST_SUM0; end
      ST_SUM0: state_next = ST_SUM1;
      ST_SUM1: state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_done) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      // cnt steps the MAC terms; in ST_ROOT it marks the root launch.
      if (state == ST_MAC && cnt != 2'd3) begin
        cnt <= cnt + 1'b1;
      end else if (state == ST_ROOT) begin
        cnt <= 2'd1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Result arithmetic.
  always_comb begin
    if (|root[RW-1:NORM_W+4]) norm = '1;
    else norm = root[NORM_W+3:4];
    priority if (norm < thr[0]) lvl = LVL_NONE;
    else if (norm < thr[1]) lvl = LVL_VERY_LOW;
    else if (norm < thr[2]) lvl = LVL_LOW;
    else if (norm < thr[3]) lvl = LVL_MEDIUM;
    else if (norm < thr[4]) lvl = LVL_HIGH;
    else lvl = LVL_VERY_HIGH;
    tot_sum = {1'b0, rd_data} + (TOTAL_W+1)'(norm);
    tot_sat = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
  end

  // Totals memory.
  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[AW'(32'(body))];
    if (state == ST_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (state == ST_DONE && ok_q) begin
      mem[addr_q] <= (req_q == REQ_ADD) ? tot_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
    if (state == ST_DONE) begin
      if (req_q == REQ_ADD) begin
        tet_norm   <= norm;
        level      <= lvl;
        body_total <= ok_q ? tot_sat : '0;
      end else begin
        tet_norm   <= '0;
        level      <= LVL_NONE;
        body_total <= '0;
      end
    end
  end

  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a finishing step");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(req_q == REQ_CLEAR) |->
      tet_norm == '0 && level == LVL_NONE && body_total == '0)
    else $error("clear transaction gave nonzero result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after taking a transaction");

  a_no_write_bad_body: assert property (@(posedge clk) disable iff (rst)
    done && $past(ok_q) == 1'b0 |-> body_total == '0)
    else $error("out-of-range body reported a total");

endmodule : tet_strain_norm_accumulator
`default_nettype wire
